/* src/bpse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bpse_pkg;

  // Default stack size and fixed field widths
  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned KindW  = 2;
  localparam int unsigned OpW    = 4;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 7;

  typedef enum logic [KindW-1:0] {
    KIND_PUSH  = 2'd0,
    KIND_OPER  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [OpW-1:0] {
    OP_IMPLY = 4'd0,
    OP_AND   = 4'd1,
    OP_OR    = 4'd2,
    OP_XOR   = 4'd3,
    OP_NOT   = 4'd4,
    OP_EQ    = 4'd5,
    OP_TERN  = 4'd6,
    OP_NE    = 4'd7,
    OP_GT    = 4'd8,
    OP_LT    = 4'd9,
    OP_GE    = 4'd10,
    OP_LE    = 4'd11
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNKNOWN   = 2'd3
  } status_e;

  // What each stack cell loads on the next edge
  typedef enum logic [1:0] {
    CELL_HOLD     = 2'd0,
    CELL_TAKE_UP  = 2'd1,
    CELL_TAKE_DN1 = 2'd2,
    CELL_TAKE_DN2 = 2'd3
  } cell_mode_e;

  // One result item
  typedef struct packed {
    logic              top_value;
    logic [StatW-1:0]  status;
    logic [CountW-1:0] stack_count;
  } result_t;

endpackage

`default_nettype wire

/* src/bpse_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one token per item
interface bpse_in_if;
  import bpse_pkg::*;

  logic           valid;
  logic           ready;
  logic [KindW-1:0] kind;
  logic           literal_value;
  logic [OpW-1:0] operator_code;

  modport source (output valid, kind, literal_value, operator_code, input ready);
  modport sink   (input valid, kind, literal_value, operator_code, output ready);
endinterface

// Output channel: one result per item
interface bpse_out_if;
  import bpse_pkg::*;

  logic              valid;
  logic              ready;
  logic              top_value;
  logic [StatW-1:0]  status;
  logic [CountW-1:0] stack_count;

  modport source (output valid, top_value, status, stack_count, input ready);
  modport sink   (input valid, top_value, status, stack_count, output ready);
endinterface

`default_nettype wire

/* src/boolean_postfix_stack_evaluator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Boolean postfix evaluator on a stack of single bits.
// in_i carries tokens: push a literal, apply an operator, or clear the stack.
// out_o carries one result item after every operator and after every faulty
// token (overflow, underflow, unknown operator code); pushes and clears give
// none. The stack is a row of bit cells with the top at cell 0: a push shifts
// every cell one place deeper, an operator writes its result into cell 0 and
// keeps deeper cells in place (NOT) or pulls them up by one or two places.
// Throughput is one token per cycle while in_i.ready is high. A result is
// registered in the output entry. When the receiver stalls, one further result is held
// in a skid entry; in_i.ready drops only while that entry is occupied, so
// tokens that give no result still pass while the output waits.
// Reset empties the stack (level zero) and both output entries; no clearing
// pass is needed, the cell contents are only read below the level.
// stack_count reports the level after the token, in 7 bits.
module boolean_postfix_stack_evaluator #(
  parameter int unsigned StackDepth = bpse_pkg::STACK_DEPTH_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  bpse_in_if.sink      in_i,
  bpse_out_if.source   out_o
);
  import bpse_pkg::*;

  localparam int unsigned LvlW = $clog2(StackDepth + 1);

  logic [LvlW-1:0] level_d, level_q;
  logic [StackDepth-1:0] cell_bits;
  cell_mode_e      top_mode, rest_mode;
  logic            accept, emit, obuf_ready;
  logic            alu_r, new_top;
  logic [1:0]      need;
  result_t         res;

  assign accept = in_i.valid & obuf_ready;
  assign in_i.ready = obuf_ready;

  // Operand count per operator
  always_comb begin
    case (in_i.operator_code)
      OP_NOT:  need = 2'd1;
      OP_TERN: need = 2'd3;
      default: need = 2'd2;
    endcase
  end

  bpse_alu u_alu (
    .op_i (in_i.operator_code),
    .a_i  (cell_bits[1]),
    .b_i  (cell_bits[0]),
    .c_i  (cell_bits[2]),
    .r_o  (alu_r)
  );

  // Decode the token into cell moves, new level and result
  always_comb begin
    level_d         = level_q;
    top_mode        = CELL_HOLD;
    rest_mode       = CELL_HOLD;
    emit            = 1'b0;
    res.top_value   = 1'b0;
    res.status      = ST_OK;
    new_top         = in_i.literal_value;
    if (accept) begin
      case (in_i.kind)
        KIND_PUSH: begin
          if (level_q >= LvlW'(StackDepth)) begin
            emit       = 1'b1;
            res.status = ST_OVERFLOW;
          end else begin
            top_mode  = CELL_TAKE_UP;
            rest_mode = CELL_TAKE_UP;
            level_d   = level_q + LvlW'(1);
          end
        end
        KIND_OPER: begin
          emit = 1'b1;
          if (in_i.operator_code > OP_LE) begin
            res.status = ST_UNKNOWN;
          end else if (level_q < LvlW'(need)) begin
            res.status = ST_UNDERFLOW;
          end else begin
            new_top       = alu_r;
            res.top_value = alu_r;
            top_mode      = CELL_TAKE_UP;
            case (need)
              2'd1:    rest_mode = CELL_HOLD;
              2'd3:    rest_mode = CELL_TAKE_DN2;
              default: rest_mode = CELL_TAKE_DN1;
            endcase
            level_d = level_q - LvlW'(need) + LvlW'(1);
          end
        end
        KIND_CLEAR: begin
          level_d = '0;
        end
        default: begin
          level_d = level_q;
        end
      endcase
    end
    res.stack_count = CountW'(level_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else begin
      level_q <= level_d;
    end
  end

  // Row of stack cells, cell 0 is the top
  for (genvar i = 0; i < StackDepth; i++) begin : g_cell
    logic up_b, dn1_b, dn2_b;
    cell_mode_e mode;

    if (i == 0) begin : g_top
      assign up_b = new_top;
      assign mode = top_mode;
    end else begin : g_mid
      assign up_b = cell_bits[i-1];
      assign mode = rest_mode;
    end

    if (i + 1 < StackDepth) begin : g_dn1
      assign dn1_b = cell_bits[i+1];
    end else begin : g_dn1_end
      assign dn1_b = 1'b0;
    end

    if (i + 2 < StackDepth) begin : g_dn2
      assign dn2_b = cell_bits[i+2];
    end else begin : g_dn2_end
      assign dn2_b = 1'b0;
    end

    bpse_cell u_cell (
      .clk_i  (clk_i),
      .mode_i (mode),
      .up_i   (up_b),
      .dn1_i  (dn1_b),
      .dn2_i  (dn2_b),
      .bit_o  (cell_bits[i])
    );
  end

  bpse_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (emit),
    .data_i  (res),
    .ready_o (obuf_ready),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

/* src/bpse_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One stack bit; takes its own value or that of a neighbor each cycle
module bpse_cell (
  input  wire                   clk_i,
  input  bpse_pkg::cell_mode_e  mode_i,
  input  wire                   up_i,
  input  wire                   dn1_i,
  input  wire                   dn2_i,
  output logic                  bit_o
);
  import bpse_pkg::*;

  logic bit_d, bit_q;

  // Select the source for the next value
  always_comb begin
    case (mode_i)
      CELL_TAKE_UP:  bit_d = up_i;
      CELL_TAKE_DN1: bit_d = dn1_i;
      CELL_TAKE_DN2: bit_d = dn2_i;
      default:       bit_d = bit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
  end

  assign bit_o = bit_q;

endmodule

`default_nettype wire

/* src/bpse_alu.sv */
`timescale 1ns / 1ps
`default_nettype none

// Boolean operator unit; c is the deepest operand, b the top one
module bpse_alu (
  input  wire [bpse_pkg::OpW-1:0] op_i,
  input  wire                     a_i,
  input  wire                     b_i,
  input  wire                     c_i,
  output logic                    r_o
);
  import bpse_pkg::*;

  always_comb begin
    case (op_i)
      OP_IMPLY: r_o = ~a_i | b_i;
      OP_AND:   r_o = a_i & b_i;
      OP_OR:    r_o = a_i | b_i;
      OP_XOR:   r_o = a_i ^ b_i;
      OP_NOT:   r_o = ~b_i;
      OP_EQ:    r_o = ~(a_i ^ b_i);
      OP_TERN:  r_o = c_i ? a_i : b_i;
      OP_NE:    r_o = a_i ^ b_i;
      OP_GT:    r_o = a_i & ~b_i;
      OP_LT:    r_o = ~a_i & b_i;
      OP_GE:    r_o = a_i | ~b_i;
      OP_LE:    r_o = ~a_i | b_i;
      default:  r_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

/* src/bpse_obuf.sv */
`timescale 1ns / 1ps
`default_nettype none

// Output register with one skid entry
module bpse_obuf (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  bpse_pkg::result_t   data_i,
  output logic                ready_o,
  bpse_out_if.source          out_o
);
  import bpse_pkg::*;

  logic    out_valid_d, out_valid_q;
  logic    skid_valid_d, skid_valid_q;
  logic    out_load, skid_load, take;
  result_t out_data_d, out_data_q;
  result_t skid_data_q;

  assign take    = out_valid_q & out_o.ready;
  assign ready_o = ~skid_valid_q;

  // Advance skid into output, or place a new item where there is room
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_load     = 1'b0;
    skid_load    = 1'b0;
    out_data_d   = data_i;
    if (skid_valid_q) begin
      if (take) begin
        out_load     = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || take) begin
        out_load    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        skid_load    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
    end
    if (skid_load) begin
      skid_data_q <= data_i;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.top_value   = out_data_q.top_value;
  assign out_o.status      = out_data_q.status;
  assign out_o.stack_count = out_data_q.stack_count;

endmodule

`default_nettype wire

/* test/boolean_postfix_stack_evaluator_tb.sv */
`timescale 1ns / 1ps

module boolean_postfix_stack_evaluator_tb;
  import bpse_pkg::*;

  localparam int unsigned DEPTH = STACK_DEPTH_DEF;
  localparam logic [KindW-1:0] KIND_IGNORED = 2'd3;
  localparam logic [OpW-1:0] OP_CODE_TOP = 4'hF;
  localparam int unsigned ITEM_TARGET = 850;
  localparam int unsigned HOLD_CYCLES = 200;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             lit;
    logic [OpW-1:0]   op;
  } token_t;

  typedef enum int unsigned {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_ALT
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;

  bpse_in_if  in_if ();
  bpse_out_if out_if ();

  boolean_postfix_stack_evaluator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  token_t      pending_tokens[$];
  result_t     awaited_results[$];
  logic        stk_bits[DEPTH];
  int unsigned stk_level;
  int unsigned planned_level;
  int unsigned tokens_counted;
  int unsigned tokens_total;
  int unsigned tokens_taken;
  int unsigned fault_count;

  // Operand count of a known operator
  function automatic int unsigned operand_need(input logic [OpW-1:0] op);
    if (op == OP_NOT) return 1;
    if (op == OP_TERN) return 3;
    return 2;
  endfunction

  // Apply one accepted token to the stack copy; return 1 when a result is due
  function automatic logic apply_token(input token_t tok, output result_t res);
    int unsigned need;
    logic a, b, c, r;
    res = '0;
    a = 1'b0;
    b = 1'b0;
    c = 1'b0;
    if (tok.kind == KIND_CLEAR) begin
      stk_level = 0;
      return 1'b0;
    end
    if (tok.kind == KIND_PUSH) begin
      if (stk_level >= DEPTH) begin
        res.status = ST_OVERFLOW;
        res.stack_count = stk_level[CountW-1:0];
        return 1'b1;
      end
      stk_bits[stk_level] = tok.lit;
      stk_level++;
      return 1'b0;
    end
    if (tok.kind != KIND_OPER) return 1'b0;

    // unknown code wins over underflow
    if (tok.op > OP_LE) begin
      res.status = ST_UNKNOWN;
      res.stack_count = stk_level[CountW-1:0];
      return 1'b1;
    end
    need = operand_need(tok.op);
    if (stk_level < need) begin
      res.status = ST_UNDERFLOW;
      res.stack_count = stk_level[CountW-1:0];
      return 1'b1;
    end

    // b on top, a below it, c deepest
    b = stk_bits[stk_level-1];
    if (need >= 2) a = stk_bits[stk_level-2];
    if (need >= 3) c = stk_bits[stk_level-3];
    case (tok.op)
      OP_IMPLY: r = !a | b;
      OP_AND:   r = a & b;
      OP_OR:    r = a | b;
      OP_XOR:   r = a ^ b;
      OP_NOT:   r = !b;
      OP_EQ:    r = !(a ^ b);
      OP_TERN:  r = c ? a : b;
      OP_NE:    r = a ^ b;
      OP_GT:    r = a & !b;
      OP_LT:    r = !a & b;
      OP_GE:    r = a | !b;
      default:  r = !a | b;
    endcase
    stk_level = stk_level - need;
    stk_bits[stk_level] = r;
    stk_level++;
    res.top_value = r;
    res.status = ST_OK;
    res.stack_count = stk_level[CountW-1:0];
    return 1'b1;
  endfunction

  // Queue one token and track the level it leads to, to shape the formulas
  task automatic queue_token(input logic [KindW-1:0] kind, input logic lit,
                             input logic [OpW-1:0] op);
    token_t tok;
    tok.kind = kind;
    tok.lit = lit;
    tok.op = op;
    pending_tokens.push_back(tok);
    tokens_total++;
    if (kind != KIND_IGNORED) tokens_counted++;
    if (kind == KIND_CLEAR) begin
      planned_level = 0;
    end else if (kind == KIND_PUSH) begin
      if (planned_level < DEPTH) planned_level++;
    end else if (kind == KIND_OPER && op <= OP_LE && planned_level >= operand_need(op)) begin
      planned_level = planned_level - operand_need(op) + 1;
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Reset and known input levels from time zero
  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_PUSH;
    in_if.literal_value = 1'b0;
    in_if.operator_code = OP_IMPLY;
    out_if.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Driver: bursts of items with random gaps between them
  int unsigned burst_left;
  int unsigned gap_left;
  token_t      next_tok;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pending_tokens.size() > 0) begin
        next_tok = pending_tokens.pop_front();
        in_if.valid <= 1'b1;
        in_if.kind <= next_tok.kind;
        in_if.literal_value <= next_tok.lit;
        in_if.operator_code <= next_tok.op;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern of its own, plus long hold-offs to fill the block
  int unsigned rx_cycle;
  int unsigned hold_left;
  int unsigned mode_left;
  rx_mode_e    rx_mode;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_cycle = 0;
      hold_left = 0;
      mode_left = 0;
      rx_mode = RX_FREE;
    end else begin
      rx_cycle++;
      if (rx_cycle == 150 || rx_cycle == 1200) hold_left = HOLD_CYCLES;
      if (mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 96);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:   out_if.ready <= 1'b1;
          RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
          default:   out_if.ready <= rx_cycle[0];
        endcase
      end
    end
  end

  // Monitor: check results, then predict from accepted items
  token_t  seen_tok;
  result_t got;
  result_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got.top_value = out_if.top_value;
        got.status = out_if.status;
        got.stack_count = out_if.stack_count;
        if (awaited_results.size() == 0) begin
          $error("unexpected result: top_value %0d status %0d stack_count %0d",
                 got.top_value, got.status, got.stack_count);
          fault_count++;
        end else begin
          want = awaited_results.pop_front();
          if (got.top_value !== want.top_value) begin
            $error("top_value: expected %0d, got %0d", want.top_value, got.top_value);
            fault_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fault_count++;
          end
          if (got.stack_count !== want.stack_count) begin
            $error("stack_count: expected %0d, got %0d", want.stack_count, got.stack_count);
            fault_count++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        seen_tok.kind = in_if.kind;
        seen_tok.lit = in_if.literal_value;
        seen_tok.op = in_if.operator_code;
        if (apply_token(seen_tok, want)) awaited_results.push_back(want);
        tokens_taken++;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned seg;
    logic [OpW-1:0] op_pick;
    stk_level = 0;
    planned_level = 0;
    tokens_counted = 0;
    tokens_total = 0;
    tokens_taken = 0;
    fault_count = 0;

    // Special cases: clear, underflow on empty, unknown code on empty, ignored kind
    queue_token(KIND_CLEAR, 1'b1, OP_CODE_TOP);
    queue_token(KIND_OPER, 1'b1, OP_AND);
    queue_token(KIND_OPER, 1'b0, OP_CODE_TOP);
    queue_token(KIND_IGNORED, 1'b1, OP_CODE_TOP);
    // ternary short of one operand
    queue_token(KIND_PUSH, 1'b1, OP_IMPLY);
    queue_token(KIND_PUSH, 1'b0, OP_IMPLY);
    queue_token(KIND_OPER, 1'b0, OP_TERN);
    queue_token(KIND_PUSH, 1'b1, OP_IMPLY);
    // every operator once, with the stack kept deep enough
    for (int o = OP_IMPLY; o <= OP_LE; o++) begin
      if (o != OP_NOT) queue_token(KIND_PUSH, 1'($urandom_range(0, 1)), OP_IMPLY);
      queue_token(KIND_OPER, 1'b0, o[OpW-1:0]);
    end

    // Random part: mostly well-formed formulas, some deep fills, clears and noise
    while (tokens_counted < ITEM_TARGET) begin
      seg = $urandom_range(0, 39);
      if (seg == 0) begin
        repeat ($urandom_range(55, 70))
          queue_token(KIND_PUSH, 1'($urandom_range(0, 1)),
                      OpW'($urandom_range(0, OP_CODE_TOP)));
      end else if (seg <= 2) begin
        queue_token(KIND_CLEAR, 1'($urandom_range(0, 1)),
                    OpW'($urandom_range(0, OP_CODE_TOP)));
      end else if (seg <= 6) begin
        repeat ($urandom_range(1, 3))
          queue_token(KindW'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      OpW'($urandom_range(0, OP_CODE_TOP)));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          op_pick = OpW'($urandom_range(OP_IMPLY, OP_LE));
          if (planned_level >= operand_need(op_pick) && $urandom_range(0, 2) != 0)
            queue_token(KIND_OPER, 1'($urandom_range(0, 1)), op_pick);
          else
            queue_token(KIND_PUSH, 1'($urandom_range(0, 1)),
                        OpW'($urandom_range(0, OP_CODE_TOP)));
        end
      end
    end

    // Drain: all items taken, all results seen, then a short settle
    while (tokens_taken < tokens_total) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
